[design/acg_pkg.sv]
// Shared types, widths and codes for the half-circle rasterizer.
`default_nettype none

package acg_pkg;

	// Width of the held centre coordinates (range 8 to 16).
	localparam int COORD_BITS = 13;

	// Fixed widths of the channel fields.
	localparam int CENTRE_BITS = 13;
	localparam int RAD_BITS    = 12;
	localparam int PIX_BITS    = 15;
	localparam int COLOUR_BITS = 32;

	// Internal arithmetic widths.
	localparam int OFF_BITS = RAD_BITS + 1;
	localparam int DEC_BITS = 16;
	localparam int SUM_BITS = ((COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS) + 2;

	// Job queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [OFF_BITS-1:0] off_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;
	typedef logic signed [SUM_BITS-1:0] sum_t;
	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic [1:0]                 pt_idx_t;

	localparam off_t OFF_ONE = off_t'(1);
	localparam dec_t DEC_ONE = dec_t'(1);

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_STEP  = 1'b1
	} func_t;

	// Point order within one step.
	localparam pt_idx_t PT_FIRST = 2'd0;
	localparam pt_idx_t PT_LAST  = 2'd3;

	// One step worth of work for the back end.
	typedef struct packed {
		coord_t cx;
		coord_t cy;
		off_t   x;
		off_t   y;
		logic   done;
	} job_t;

endpackage

`default_nettype wire

[design/andres_circle_half_generator_core.sv]
// Top level of the Andres lower-half circle rasterizer.
`default_nettype none

// Channel   Handshake              Payload
// -------   --------------------   ------------------------------------------------
// cfg       cfg_valid/cfg_ready    draw_colour
// in        in_valid/in_ready      func, centre_x, centre_y, radius
// out       out_valid/out_ready    pixel_x, pixel_y, colour, last_of_step, circle_done
//
// A start item is taken by the front end and yields nothing; a step item is taken by the
// front end and queued, and the output register then emits its four points one by one,
// so a run of steps is paced by the single output port.
// Up to two step jobs wait in the queue, so the front keeps taking items while points drain.
// Reset clears the circle state, the queue and the output valid; the colour resets to zero.
// Stalls on out_ready hold the current point and back up into the queue and then in_ready.

module andres_circle_half_generator_core import acg_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [COLOUR_BITS-1:0] draw_colour,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   func,
	input  wire logic [CENTRE_BITS-1:0] centre_x,
	input  wire logic [CENTRE_BITS-1:0] centre_y,
	input  wire logic [RAD_BITS-1:0]    radius,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [PIX_BITS-1:0]  pixel_x,
	output logic signed [PIX_BITS-1:0]  pixel_y,
	output logic [COLOUR_BITS-1:0]      colour,
	output logic                        last_of_step,
	output logic                        circle_done
);

	logic [COLOUR_BITS-1:0] colour_q;
	logic push, push_ready, pop, head_valid;
	job_t push_job, head_job;

	// Colour register: always writable; the user must change it only while the block is idle (not enforced here)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			colour_q <= draw_colour;
		end
	end

	// Front: classify items, advance the circle, queue one job per live step
	acg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.centre_x (centre_x),
		.centre_y (centre_y),
		.radius   (radius),
		.push     (push),
		.push_job (push_job),
		.q_ready  (push_ready)
	);

	// Queue: decouple item intake from point emission
	acg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back: emit the four symmetric points of each job
	acg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.colour_cfg   (colour_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.colour       (colour),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

endmodule

`default_nettype wire

[design/acg_front.sv]
// Front end: takes start and step items, runs the Andres update, queues step jobs.
`default_nettype none

module acg_front import acg_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   func,
	input  wire logic [CENTRE_BITS-1:0] centre_x,
	input  wire logic [CENTRE_BITS-1:0] centre_y,
	input  wire logic [RAD_BITS-1:0]    radius,
	output logic                        push,
	output job_t                        push_job,
	input  wire logic                   q_ready
);

	logic               busy_q;
	off_t               x_q;
	off_t               y_q;
	dec_t               d_q;
	coord_t             cx_q;
	coord_t             cy_q;
	logic [RAD_BITS-1:0] r_q;

	dec_t xe, ye, re, two_x, two_ry, d_b1, d_b2, d_b3, d_n, yx1;
	off_t x_n, y_n;
	logic take_b1, take_b2, done_n, accept, is_start;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign is_start = (func_t'(func) == FUNC_START);
	assign push     = accept && !is_start && busy_q;

	// Three-way decision update
	always_comb begin
		xe      = dec_t'(x_q);
		ye      = dec_t'(y_q);
		re      = dec_t'({1'b0, r_q});
		two_x   = xe + xe;
		two_ry  = (re - ye) + (re - ye);
		yx1     = ye - xe - DEC_ONE;
		d_b1    = d_q - two_x - DEC_ONE;
		d_b2    = d_q + ye + ye - DEC_ONE;
		d_b3    = d_q + yx1 + yx1;
		take_b1 = (d_q >= two_x);
		take_b2 = (d_q < two_ry);
		priority if (take_b1) begin
			d_n = d_b1;
			x_n = x_q + OFF_ONE;
			y_n = y_q;
		end else if (take_b2) begin
			d_n = d_b2;
			x_n = x_q;
			y_n = y_q - OFF_ONE;
		end else begin
			d_n = d_b3;
			x_n = x_q + OFF_ONE;
			y_n = y_q - OFF_ONE;
		end
		done_n = (y_n < x_n);
	end

	always_comb begin
		push_job.cx   = cx_q;
		push_job.cy   = cy_q;
		push_job.x    = x_q;
		push_job.y    = y_q;
		push_job.done = done_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			x_q    <= '0;
			y_q    <= '0;
			d_q    <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
			r_q    <= '0;
		end else if (accept) begin
			if (is_start) begin
				busy_q <= 1'b1;
				cx_q   <= coord_t'(centre_x);
				cy_q   <= coord_t'(centre_y);
				r_q    <= radius;
				x_q    <= '0;
				y_q    <= off_t'({1'b0, radius});
				d_q    <= dec_t'({1'b0, radius}) - DEC_ONE;
			end else if (busy_q) begin
				x_q    <= x_n;
				y_q    <= y_n;
				d_q    <= d_n;
				busy_q <= !done_n;
			end
		end
	end

	// Idle only after a finishing step or while no circle was started
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(push && push_job.done))
		else $error("busy dropped without a finishing step");

endmodule

`default_nettype wire

[design/acg_queue.sv]
// Short job queue between the front and back ends.
`default_nettype none

module acg_queue import acg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      push_ready,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	job_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
		logic [QPTR_BITS-1:0] n;
		if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) n = '0;
		else n = p + QPTR_BITS'(1);
		return n;
	endfunction

	assign push_ready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && push_ready) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop && head_valid) rd_ptr_q <= next_ptr(rd_ptr_q);
			unique case ({push && push_ready, pop && head_valid})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

[design/acg_back.sv]
// Back end: expands each step job into four mirrored points, one per cycle unless out_ready stalls.
`default_nettype none

module acg_back import acg_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   head_valid,
	input  wire job_t                   head_job,
	output logic                        pop,
	input  wire logic [COLOUR_BITS-1:0] colour_cfg,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [PIX_BITS-1:0]  pixel_x,
	output logic signed [PIX_BITS-1:0]  pixel_y,
	output logic [COLOUR_BITS-1:0]      colour,
	output logic                        last_of_step,
	output logic                        circle_done
);

	pt_idx_t pt_q;
	logic    out_valid_q;
	logic    advance, load, is_last, swap, mirror;
	sum_t    cx, cy, ox, oy, px, py;

	assign advance = !out_valid_q || out_ready;
	assign load    = advance && head_valid;
	assign is_last = (pt_q == PT_LAST);
	assign pop     = load && is_last;

	// Odd points swap x and y, the second pair mirrors about the centre column
	always_comb begin
		swap   = pt_q[0];
		mirror = pt_q[1];
		cx     = sum_t'({1'b0, head_job.cx});
		cy     = sum_t'({1'b0, head_job.cy});
		ox     = swap ? sum_t'(head_job.y) : sum_t'(head_job.x);
		oy     = swap ? sum_t'(head_job.x) : sum_t'(head_job.y);
		px     = mirror ? (cx - ox) : (cx + ox);
		py     = cy + oy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pt_q        <= PT_FIRST;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) pt_q <= pt_q + pt_idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_x      <= px[PIX_BITS-1:0];
			pixel_y      <= py[PIX_BITS-1:0];
			colour       <= colour_cfg;
			last_of_step <= is_last;
			circle_done  <= is_last && head_job.done;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && circle_done |-> last_of_step)
		else $error("circle end flagged off a step boundary");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (pt_q == PT_FIRST))
		else $error("point index not wrapped after fourth point");

endmodule

`default_nettype wire
